### design/urs_pkg.sv
// shared widths, register map, reset values and chain types for the unique random sampler
package urs_pkg;

    localparam int RAW_W         = 31;
    localparam int VAL_W         = 16;
    localparam int CNT_W         = 5;
    localparam int IDX_W         = 4;
    localparam int REM_W         = VAL_W + 1;
    localparam int DRAW_W        = VAL_W + 2;
    localparam int RANGE_W       = VAL_W + 2;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int MAX_PICKS_DEF = 16;

    localparam logic [VAL_W-1:0] LOW_RESET   = '0;
    localparam logic [VAL_W-1:0] HIGH_RESET  = '1;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

    typedef enum logic [1:0] {
        REG_RANGE_LOW  = 2'd0,
        REG_RANGE_HIGH = 2'd1,
        REG_PICK_COUNT = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MOD,
        ST_WALK,
        ST_DONE
    } t_state;

    // running draw that travels down the chain
    typedef struct packed {
        logic              vld;
        logic [DRAW_W-1:0] draw;
    } t_token;

    // per-cell occupancy seen from the fill level
    typedef struct packed {
        logic active;
        logic at_end;
    } t_cell_ctl;

    // sorted insert broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [VAL_W-1:0] value;
    } t_ins;

endpackage

### design/urs_mod.sv
// restoring serial modulo: one dividend bit per cycle
module urs_mod import urs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAW_W-1:0] i_dividend,
    input  logic [REM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [REM_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(RAW_W + 1);

    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [REM_W-1:0]  r_rem;
    logic [RAW_W-1:0]  r_dvd;
    logic [REM_W-1:0]  r_div;
    logic [REM_W:0]    w_trial;
    logic [REM_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[RAW_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = REM_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = REM_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == STEP_W'(1));
            if (i_start) begin
                r_cnt <= STEP_W'(RAW_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[RAW_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### design/urs_cell.sv
// one cell of the sorted pick chain: stores a pick, bumps the passing draw, shifts on insert
module urs_cell import urs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_token           i_tok,
    output t_token           o_tok,
    input  t_cell_ctl        i_ctl,
    input  t_ins             i_ins,
    input  logic [VAL_W-1:0] i_prev_val,
    input  logic             i_prev_gt,
    output logic [VAL_W-1:0] o_val,
    output logic             o_gt
);

    logic              r_tok_vld;
    logic [DRAW_W-1:0] r_draw;
    logic [VAL_W-1:0]  r_val;
    logic              w_bump;

    assign w_bump = i_ctl.active && ({2'b00, r_val} <= i_tok.draw);
    assign o_gt   = i_ctl.active && (r_val > i_ins.value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_draw <= i_tok.draw + DRAW_W'(w_bump);
        end
    end

    // larger entries move up one place; first larger cell, else end cell, takes the new pick
    always_ff @(posedge i_clk) begin
        if (i_ins.en) begin
            if (i_prev_gt) begin
                r_val <= i_prev_val;
            end else if (o_gt || i_ctl.at_end) begin
                r_val <= i_ins.value;
            end
        end
    end

    assign o_tok.vld  = r_tok_vld;
    assign o_tok.draw = r_draw;
    assign o_val      = r_val;

endmodule

### design/unique_random_sampler.sv
// Unique random sampler: draws distinct values from [range_low, range_high], one per raw
// random word. An item runs a serial modulo, then passes its draw down the chain of stored
// picks; a pick whose range is negative skips both, and a pick whose range is zero skips the
// modulo. One item is in flight at a time; a finished result waits in the output register
// while the next item is taken. Registers are written at 0x0, 0x4, 0x8.
module unique_random_sampler import urs_pkg::*; #(
    parameter int MAX_PICKS = MAX_PICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [RAW_W-1:0]  i_raw_random,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_picked_value,
    output logic [IDX_W-1:0]  o_pick_index,
    output logic              o_last_of_set,
    output logic              o_range_exhausted,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int HELD_W = $clog2(MAX_PICKS + 1);

    t_state             r_state;
    t_state             n_state;
    logic [VAL_W-1:0]   r_low;
    logic [VAL_W-1:0]   r_high;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_picks_done;
    logic [HELD_W-1:0]  r_held;
    logic [CNT_W-1:0]   r_idx;
    logic [RAW_W-1:0]   r_raw;
    logic [VAL_W-1:0]   r_res_value;
    logic               r_res_exh;
    logic               r_out_vld;
    logic [VAL_W-1:0]   r_out_value;
    logic [IDX_W-1:0]   r_out_index;
    logic               r_out_last;
    logic               r_out_exh;

    logic [CNT_W-1:0]   w_eff_count;
    logic               w_boundary;
    logic [RANGE_W-1:0] w_range;
    logic               w_accept;
    logic               w_cfg_wr;
    logic               w_mod_start;
    logic               w_mod_done;
    logic [REM_W-1:0]   w_mod_rem;
    logic               w_inject;
    logic [DRAW_W-1:0]  w_inject_draw;
    logic               w_walk_end;
    logic               w_walk_exh;
    logic               w_load;
    logic [CNT_W-1:0]   w_next_done;
    t_ins               w_ins;

    t_token             w_tok [0:MAX_PICKS];
    logic [VAL_W-1:0]   w_val [0:MAX_PICKS-1];
    logic               w_gt  [0:MAX_PICKS-1];

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= LOW_RESET;
            r_high  <= HIGH_RESET;
            r_count <= COUNT_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[ADDR_W-1:2]))
                REG_RANGE_LOW:  r_low   <= pwdata[VAL_W-1:0];
                REG_RANGE_HIGH: r_high  <= pwdata[VAL_W-1:0];
                REG_PICK_COUNT: r_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[ADDR_W-1:2]))
            REG_RANGE_LOW:  prdata = DATA_W'(r_low);
            REG_RANGE_HIGH: prdata = DATA_W'(r_high);
            REG_PICK_COUNT: prdata = DATA_W'(r_count);
            default:        prdata = '0;
        endcase
    end

    // pick count of zero behaves as one, clamp to the chain length
    always_comb begin
        w_eff_count = (r_count == '0) ? CNT_W'(1) : r_count;
        if (int'(w_eff_count) > MAX_PICKS) begin
            w_eff_count = CNT_W'(MAX_PICKS);
        end
    end

    assign w_boundary  = (r_picks_done >= w_eff_count);
    assign w_range     = RANGE_W'({2'b00, r_high}) - RANGE_W'({2'b00, r_low})
                       + RANGE_W'(1) - RANGE_W'(r_idx);
    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign w_walk_end  = w_tok[MAX_PICKS].vld;
    assign w_walk_exh  = (w_tok[MAX_PICKS].draw > {2'b00, r_high});
    assign w_next_done = r_idx + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_mod_start   = 1'b0;
        w_inject      = 1'b0;
        w_inject_draw = {2'b00, r_low};
        w_ins.en      = 1'b0;
        w_ins.value   = w_tok[MAX_PICKS].draw[VAL_W-1:0];
        w_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (w_range[RANGE_W-1]) begin
                    n_state = ST_DONE;
                end else if (w_range == '0) begin
                    w_inject = 1'b1;
                    n_state  = ST_WALK;
                end else begin
                    w_mod_start = 1'b1;
                    n_state     = ST_MOD;
                end
            end
            ST_MOD: begin
                w_inject_draw = DRAW_W'(w_mod_rem) + {2'b00, r_low};
                if (w_mod_done) begin
                    w_inject = 1'b1;
                    n_state  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_walk_end) begin
                    w_ins.en = !w_walk_exh && (int'(r_held) < MAX_PICKS);
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_picks_done <= '0;
            r_held       <= '0;
        end else begin
            if (w_accept && w_boundary) begin
                r_picks_done <= '0;
                r_held       <= '0;
            end else if (w_ins.en) begin
                r_held <= r_held + HELD_W'(1);
            end
            if (w_load) begin
                r_picks_done <= w_next_done;
            end
        end
    end

    // item payload and pick result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw <= i_raw_random;
            r_idx <= w_boundary ? '0 : r_picks_done;
        end
        if (r_state == ST_PREP && w_range[RANGE_W-1]) begin
            r_res_exh   <= 1'b1;
            r_res_value <= '0;
        end else if (r_state == ST_WALK && w_walk_end) begin
            r_res_exh   <= w_walk_exh;
            r_res_value <= w_walk_exh ? '0 : w_tok[MAX_PICKS].draw[VAL_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= r_res_value;
            r_out_index <= r_idx[IDX_W-1:0];
            r_out_last  <= (w_next_done == w_eff_count);
            r_out_exh   <= r_res_exh;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_picked_value    = r_out_value;
    assign o_pick_index      = r_out_index;
    assign o_last_of_set     = r_out_last;
    assign o_range_exhausted = r_out_exh;

    urs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_raw),
        .i_divisor  (w_range[REM_W-1:0]),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign w_tok[0].vld  = w_inject;
    assign w_tok[0].draw = w_inject_draw;

    for (genvar k = 0; k < MAX_PICKS; k++) begin : g_cell
        t_cell_ctl        w_ctl;
        logic [VAL_W-1:0] w_prev_val;
        logic             w_prev_gt;

        assign w_ctl.active = (HELD_W'(k) < r_held);
        assign w_ctl.at_end = (HELD_W'(k) == r_held);

        if (k == 0) begin : g_head
            assign w_prev_val = '0;
            assign w_prev_gt  = 1'b0;
        end else begin : g_body
            assign w_prev_val = w_val[k-1];
            assign w_prev_gt  = w_gt[k-1];
        end

        urs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1]),
            .i_ctl      (w_ctl),
            .i_ins      (w_ins),
            .i_prev_val (w_prev_val),
            .i_prev_gt  (w_prev_gt),
            .o_val      (w_val[k]),
            .o_gt       (w_gt[k])
        );
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_held) <= MAX_PICKS)
        else $error("stored pick count beyond chain length");

    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_exhausted) |-> (o_picked_value == '0))
        else $error("exhausted pick carries a value");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && !w_walk_end))
        else $error("transaction accepted while work still in flight");

    a_insert_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins.en |-> (r_state == ST_WALK && !r_res_exh || r_state == ST_WALK))
        else $error("insert outside the walk");
`endif

endmodule
